// ===== rtl/core/bksrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bksrs_pkg
// Shared types and constants for the bounded key set with rank select.
// ----------------------------------------------------------------------------
package bksrs_pkg;

  localparam int KEY_W   = 32;
  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_GET      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GETR,
    ST_GETW,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } bst_t;

endpackage

// ===== rtl/core/bksrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bksrs_front
// Input register stage: takes request beats and decodes the opcode.
// ----------------------------------------------------------------------------
module bksrs_front
  import bksrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [KEY_W-1:0]  key,
  input  logic [RANK_W-1:0] rank,
  output logic              push_valid,
  input  logic              push_ready,
  output item_t             push_item
);

  logic  fr_valid;
  item_t fr_item;
  op_t   op_dec;

  always_comb begin
    unique case (opcode)
      2'd0:    op_dec = OP_INSERT;
      2'd1:    op_dec = OP_ERASE;
      2'd2:    op_dec = OP_CONTAINS;
      default: op_dec = OP_GET;
    endcase
  end

  assign in_ready   = !fr_valid || push_ready;
  assign push_valid = fr_valid;
  assign push_item  = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item.op   <= op_dec;
      fr_item.key  <= key;
      fr_item.rank <= rank;
    end
  end

endmodule

// ===== rtl/core/bksrs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bksrs_queue
// Short FIFO that decouples the front stage from the back engine.
// ----------------------------------------------------------------------------
module bksrs_queue
  import bksrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t            qmem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     fill;
  logic             push;
  logic             pop;

  assign push_ready = (fill != (QAW+1)'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = qmem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bksrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bksrs_back
// Execution engine: keeps the keys sorted in a RAM and runs one operation
// at a time (scan, shift, place, rank read), then registers the result.
// ----------------------------------------------------------------------------
module bksrs_back
  import bksrs_pkg::*;
#(
  parameter int SET_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  item_t              q_item,
  input  logic [CAP_W-1:0]   cap_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [KEY_W-1:0]   key_out,
  output logic [COUNT_W-1:0] count_now
);

  localparam int AW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW   = $clog2(SET_DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int CRW  = (CW > RANK_W) ? CW : RANK_W;

  bst_t state, state_next;

  // Control
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] sh_left;
  logic          pend;
  logic          res_valid;

  // Working payload
  op_t               cur_op;
  logic [KEY_W-1:0]  cur_key;
  logic [RANK_W-1:0] cur_rank;
  logic [CW-1:0]     pos;
  logic [AW-1:0]     sh_addr;
  logic [AW-1:0]     pend_addr;
  logic              r_ok;
  logic [KEY_W-1:0]  r_key;
  logic              res_ok;
  logic [KEY_W-1:0]  res_key;
  logic [COUNT_W-1:0] res_count;

  // Sorted key RAM
  logic [KEY_W-1:0] mem [SET_DEPTH];
  logic [KEY_W-1:0] mem_rd;
  logic [KEY_W-1:0] mem_wd;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic             mem_we;

  logic          scan_hit, scan_past, scan_end, scan_stop, issue_rd;
  logic [CW-1:0] scan_pos, pos_inc;
  logic          has_room, rank_ok, shift_done, shift_up, res_load;

  // Scan walks the sorted keys; a greater key ends the search early
  always_comb begin
    scan_hit  = pend && (mem_rd == cur_key);
    scan_past = pend && (mem_rd > cur_key);
    scan_end  = !pend && (idx >= count);
    scan_stop = scan_hit || scan_past || scan_end;
    issue_rd  = !scan_stop && (idx < count);
    scan_pos  = scan_end ? count : CW'(pend_addr);
    pos_inc   = scan_pos + CW'(1);
  end

  assign has_room   = (CMPW'(count) < CMPW'(cap_limit)) &&
                      (CMPW'(count) < CMPW'(SET_DEPTH));
  assign rank_ok    = CRW'(cur_rank) < CRW'(count);
  assign shift_done = !pend && (sh_left == '0);
  assign shift_up   = (cur_op == OP_INSERT);
  assign res_load   = (state == ST_DONE) && (!res_valid || out_ready);

  assign out_valid = res_valid;
  assign ok        = res_ok;
  assign key_out   = res_key;
  assign count_now = res_count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.op == OP_GET) ? ST_GETR : ST_SCAN;
        end
      end
      ST_GETR: state_next = rank_ok ? ST_GETW : ST_DONE;
      ST_GETW: state_next = ST_DONE;
      ST_SCAN: begin
        if (scan_stop) begin
          unique case (cur_op)
            OP_INSERT: begin
              if (scan_hit || !has_room) begin
                state_next = ST_DONE;
              end else if (scan_pos < count) begin
                state_next = ST_SHIFT;
              end else begin
                state_next = ST_PLACE;
              end
            end
            OP_ERASE: begin
              state_next = (scan_hit && (pos_inc < count)) ? ST_SHIFT : ST_DONE;
            end
            OP_CONTAINS: state_next = ST_DONE;
            OP_GET:      state_next = ST_DONE;
          endcase
        end
      end
      ST_SHIFT: begin
        if (shift_done) begin
          state_next = shift_up ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: queue pop and RAM port controls
  always_comb begin
    q_ready = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = pend_addr;
    mem_wd  = mem_rd;
    mem_ra  = AW'(idx);
    unique case (state)
      ST_IDLE:  q_ready = 1'b1;
      ST_GETR:  mem_ra  = AW'(cur_rank);
      ST_SHIFT: begin
        mem_we = pend;
        mem_ra = sh_addr;
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        mem_wa = AW'(pos);
        mem_wd = cur_key;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      sh_left   <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          idx  <= '0;
          pend <= 1'b0;
        end
        ST_SCAN: begin
          pend <= issue_rd;
          if (issue_rd) begin
            idx <= idx + CW'(1);
          end
          if (scan_stop) begin
            sh_left <= shift_up ? (count - scan_pos) : (count - pos_inc);
            if (cur_op == OP_ERASE && scan_hit && !(pos_inc < count)) begin
              count <= count - CW'(1);
            end
          end
        end
        ST_SHIFT: begin
          pend <= (sh_left != '0);
          if (sh_left != '0) begin
            sh_left <= sh_left - CW'(1);
          end
          if (shift_done && !shift_up) begin
            count <= count - CW'(1);
          end
        end
        ST_PLACE: count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_op   <= q_item.op;
      cur_key  <= q_item.key;
      cur_rank <= q_item.rank;
      r_ok     <= 1'b0;
      r_key    <= '0;
    end
    if (state == ST_SCAN) begin
      if (issue_rd) begin
        pend_addr <= AW'(idx);
      end
      if (scan_stop) begin
        pos     <= scan_pos;
        r_ok    <= shift_up ? 1'b0 : scan_hit;
        sh_addr <= shift_up ? AW'(count - CW'(1)) : AW'(pos_inc);
      end
    end
    if (state == ST_SHIFT && sh_left != '0) begin
      pend_addr <= shift_up ? sh_addr + AW'(1) : sh_addr - AW'(1);
      sh_addr   <= shift_up ? sh_addr - AW'(1) : sh_addr + AW'(1);
    end
    if (state == ST_PLACE) begin
      r_ok <= 1'b1;
    end
    if (state == ST_GETW) begin
      r_ok  <= 1'b1;
      r_key <= mem_rd;
    end
    if (res_load) begin
      res_ok    <= r_ok;
      res_key   <= r_key;
      res_count <= COUNT_W'(count);
    end
  end

  // Key RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

endmodule

// ===== rtl/core/bounded_key_set_with_rank_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_key_set_with_rank_select
// Bounded set of distinct keys with insert, erase, contains and get-by-rank.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready) carries opcode, key and rank; every
//   request beat yields exactly one result beat on the response channel
//   (out_valid/out_ready) with ok, key_out and count_now, in request order.
//   cfg_valid/cfg_ready writes capacity_limit (always ready); write it only
//   while no request is in flight.
//   Keys are kept sorted in a single-port-write RAM, so a get is one RAM
//   read and the other operations walk the stored keys one per cycle.
//   Steps per request in the back engine:
//     get       read the key held at that rank
//     contains  scan until a match, a greater key or the end
//     erase     scan to the key, shift the tail down
//     insert    scan to the slot, shift the tail up, place the key
//   A two-entry queue and an input register sit ahead of the engine, so new
//   requests are taken while the engine works and while a result waits.
//   Reset (rst, synchronous) empties the set, drops queued requests and sets
//   capacity_limit to 64. RAM contents are not cleared; only held entries
//   reach a result. If out_ready stays low, the result register holds, the
//   engine parks, and the queue fills until in_ready drops.
// ----------------------------------------------------------------------------
module bounded_key_set_with_rank_select
  import bksrs_pkg::*;
#(
  parameter int SET_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [KEY_W-1:0]   key,
  input  logic [RANK_W-1:0]  rank,
  // response channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [KEY_W-1:0]   key_out,
  output logic [COUNT_W-1:0] count_now,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   capacity_limit
);

  logic             cap_limit;
  logic [CAP_W-1:0] cap_reg;

  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid, qb_ready;
  item_t qb_item;

  // Capacity register; writes are taken in any cycle
  assign cfg_ready = 1'b1;
  assign cap_limit = (cap_reg != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_reg <= capacity_limit;
    end
  end

  // Front: input register and opcode decode
  bksrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .key        (key),
    .rank       (rank),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  // Decoupling queue
  bksrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // Back: sorted store engine and result register. A zero limit blocks
  // every insert, same as any full set.
  bksrs_back #(
    .SET_DEPTH (SET_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .cap_limit (cap_limit ? cap_reg : '0),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .key_out   (key_out),
    .count_now (count_now)
  );

endmodule

// ===== bench/bksrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bksrs_checker
// Watches the request, response and capacity channels of the key set, keeps
// its own copy of the held keys, predicts each response and compares it.
// ----------------------------------------------------------------------------
module bksrs_checker
  import bksrs_pkg::*;
#(
  parameter int SET_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [KEY_W-1:0]   key,
  input  logic [RANK_W-1:0]  rank,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               ok,
  input  logic [KEY_W-1:0]   key_out,
  input  logic [COUNT_W-1:0] count_now,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CAP_W-1:0]   capacity_limit,
  output int                 mismatches,
  output int                 pending_results
);

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key_out;
    logic [COUNT_W-1:0] count_now;
  } reply_t;

  logic [KEY_W-1:0] held_keys[$];  // insertion order; the block keeps them sorted
  logic [CAP_W-1:0] cap_copy;
  reply_t           replies_due[$];

  // Apply one operation to the key copy and return the response it gives.
  function automatic reply_t apply_op(op_t op, logic [KEY_W-1:0] k,
                                      logic [RANK_W-1:0] r);
    reply_t rep;
    int     slot;
    int     room;
    int     smaller;
    rep  = '0;
    slot = -1;
    foreach (held_keys[i])
      if (slot < 0 && held_keys[i] == k) slot = i;
    room = (cap_copy > SET_DEPTH) ? SET_DEPTH : int'(cap_copy);
    case (op)
      OP_INSERT: begin
        if (slot < 0 && held_keys.size() < room) begin
          held_keys.push_back(k);
          rep.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (slot >= 0) begin
          held_keys.delete(slot);
          rep.ok = 1'b1;
        end
      end
      OP_CONTAINS: rep.ok = (slot >= 0);
      default: begin
        // rank-th smallest: the key with exactly r smaller keys held
        if (r < held_keys.size()) begin
          foreach (held_keys[i]) begin
            if (!rep.ok) begin
              smaller = 0;
              foreach (held_keys[j])
                if (held_keys[j] < held_keys[i]) smaller++;
              if (smaller == r) begin
                rep.ok      = 1'b1;
                rep.key_out = held_keys[i];
              end
            end
          end
        end
      end
    endcase
    rep.count_now = COUNT_W'(held_keys.size());
    return rep;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      held_keys.delete();
      replies_due.delete();
      cap_copy   = CAP_RESET;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_copy = capacity_limit;
      // response first: it always belongs to an older request
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("response beat with nothing pending: ok=%0b key_out=%h count_now=%0d",
                 ok, key_out, count_now);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, ok);
            mismatches++;
          end
          if (key_out !== want.key_out) begin
            $error("key_out: expected %h, got %h", want.key_out, key_out);
            mismatches++;
          end
          if (count_now !== want.count_now) begin
            $error("count_now: expected %0d, got %0d", want.count_now, count_now);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(apply_op(op_t'(opcode), key, rank));
    end
    pending_results = replies_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, erase, contains and get-by-rank requests into the key set
// under several capacity settings: a directed opening, then random traffic
// in bursts against a stalling response sink. The checker beside the block
// predicts and compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bksrs_pkg::*;

  localparam int SET_DEPTH   = 64;
  localparam int HOLD_CYCLES = 500;   // one long response stall
  localparam int STUCK_LIMIT = 4000;  // cycles with no beat on any channel
  localparam int TAIL_CYCLES = 150;   // > worst engine time with a full set

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic [KEY_W-1:0]   key;
  logic [RANK_W-1:0]  rank;
  logic               out_valid;
  logic               out_ready;
  logic               ok;
  logic [KEY_W-1:0]   key_out;
  logic [COUNT_W-1:0] count_now;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   capacity_limit;

  int mismatches;
  int pending_results;
  int stuck_cycles;
  bit squeeze_req;   // asks the sink for its one long hold-off

  bounded_key_set_with_rank_select #(
    .SET_DEPTH(SET_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .key           (key),
    .rank          (rank),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .key_out       (key_out),
    .count_now     (count_now),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .capacity_limit(capacity_limit)
  );

  bksrs_checker #(
    .SET_DEPTH(SET_DEPTH)
  ) set_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .key            (key),
    .rank           (rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .key_out        (key_out),
    .count_now      (count_now),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_limit (capacity_limit),
    .mismatches     (mismatches),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: any beat on any channel restarts the count.
  initial stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Response sink: segments of always-ready, coin-flip and mostly-stalled
  // ready, plus one long hold-off on request so the request side backs up.
  initial begin : result_sink
    int  style;
    int  seg_len;
    bit  held;
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      if (squeeze_req && !held) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      style   = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 60);
      repeat (seg_len) begin
        @(negedge clk);
        case (style)
          0, 1:    out_ready <= 1'b1;
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request beat; returns on the falling edge after acceptance
  // with valid still high, so back-to-back beats need no toggle.
  task automatic send_request(op_t op, logic [KEY_W-1:0] k, logic [RANK_W-1:0] r);
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    rank     <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted response has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Only called with nothing in flight.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_valid      <= 1'b1;
    capacity_limit <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic at one capacity. Keys come mostly from a small pool so
  // that duplicates, hits on erase and full-set rejects are common; one in
  // ten keys is fresh noise. Rank mostly stays inside the reachable count.
  task automatic run_traffic(logic [CAP_W-1:0] cap, int items, int pool_size,
                             int insert_pct, int erase_pct);
    logic [KEY_W-1:0]  pool[$];
    logic [KEY_W-1:0]  k;
    logic [RANK_W-1:0] r;
    op_t               op;
    int                pick;
    int                rank_top;
    int                burst_left;
    int                gap;
    write_capacity(cap);
    pool.push_back('0);
    pool.push_back('1);
    while (pool.size() < pool_size) pool.push_back($urandom);
    rank_top   = (cap > 63) ? 63 : int'(cap);
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct)
        op = OP_INSERT;
      else if (pick < insert_pct + erase_pct)
        op = OP_ERASE;
      else if (pick < insert_pct + erase_pct + (100 - insert_pct - erase_pct) / 2)
        op = OP_CONTAINS;
      else
        op = OP_GET;
      k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                      : pool[$urandom_range(0, pool.size() - 1)];
      r = ($urandom_range(0, 3) == 0) ? RANK_W'($urandom_range(0, 63))
                                      : RANK_W'($urandom_range(0, rank_top));
      send_request(op, k, r);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = OP_INSERT;
    key            = '0;
    rank           = '0;
    cfg_valid      = 1'b0;
    capacity_limit = CAP_RESET;
    squeeze_req    = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Small capacity: empty-set get and erase, key extremes, duplicate,
    // full set, hit and miss, rank select, rank at and past the count.
    write_capacity(7'd3);
    send_request(OP_GET,      32'h0000_0000, 6'd0);
    send_request(OP_ERASE,    32'h0000_0001, 6'd0);
    send_request(OP_INSERT,   32'h0000_0000, 6'd0);
    send_request(OP_INSERT,   32'hFFFF_FFFF, 6'd63);
    send_request(OP_INSERT,   32'h0000_0000, 6'd0);
    send_request(OP_INSERT,   32'h8000_0000, 6'd0);
    send_request(OP_INSERT,   32'h0000_0001, 6'd0);
    send_request(OP_CONTAINS, 32'hFFFF_FFFF, 6'd0);
    send_request(OP_CONTAINS, 32'h7FFF_FFFF, 6'd0);
    send_request(OP_GET,      32'hDEAD_BEEF, 6'd0);   // key ignored by get
    send_request(OP_GET,      32'h0000_0000, 6'd2);
    send_request(OP_GET,      32'h0000_0000, 6'd3);
    send_request(OP_GET,      32'h0000_0000, 6'd63);
    send_request(OP_ERASE,    32'h0000_0000, 6'd0);   // head erase, tail shifts
    send_request(OP_ERASE,    32'h0000_0000, 6'd0);   // now absent
    send_request(OP_GET,      32'h0000_0000, 6'd1);
    wait_drained();

    // Capacity dropped under the held count: inserts fail until erases
    // bring the count below the limit.
    write_capacity(7'd1);
    send_request(OP_INSERT, 32'h0000_0005, 6'd0);
    send_request(OP_ERASE,  32'h8000_0000, 6'd0);
    send_request(OP_INSERT, 32'h0000_0005, 6'd0);
    send_request(OP_ERASE,  32'hFFFF_FFFF, 6'd0);
    send_request(OP_INSERT, 32'h0000_0005, 6'd0);
    send_request(OP_INSERT, 32'h0000_0006, 6'd0);
    wait_drained();

    // Zero capacity: nothing can go in.
    write_capacity(7'd0);
    send_request(OP_INSERT, 32'h0000_0009, 6'd0);
    send_request(OP_ERASE,  32'h0000_0005, 6'd0);
    send_request(OP_INSERT, 32'h0000_0009, 6'd0);
    wait_drained();

    // Top register value saturates to the depth; insert-heavy so the set
    // fills to 64. The sink's long hold-off lands inside this phase.
    squeeze_req = 1'b1;
    run_traffic(7'd127, 450, 100, 55, 15);
    run_traffic(7'd64,  200, 100, 25, 45);   // erase-heavy, count falls
    run_traffic(7'd1,    80,   6, 40, 30);
    run_traffic(7'd0,    40,   6, 40, 30);
    run_traffic(7'd33,  200,  40, 45, 25);
    run_traffic(7'd64,  300,  70, 50, 20);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
